### sv/stereo_volume_fade_silence_assert.svh
// Assertion macros shared by the stereo volume block.
// They expect signals named clk and arst_n in the using scope.
`ifndef STEREO_VOLUME_FADE_SILENCE_ASSERT_SVH
`define STEREO_VOLUME_FADE_SILENCE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SVFS_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SVFS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### sv/svfs_pkg.sv
// ----------------------------------------------------------------------------
// svfs_pkg
// Types, register codes and table helpers for the stereo volume block.
// ----------------------------------------------------------------------------
package svfs_pkg;

	localparam logic [2:0] REG_REL_VOLUME     = 3'd0;
	localparam logic [2:0] REG_FADE_MODE      = 3'd1;
	localparam logic [2:0] REG_FADING_ENABLED = 3'd2;
	localparam logic [2:0] REG_PLAY_FOREVER   = 3'd3;
	localparam logic [2:0] REG_TRACK_LENGTH   = 3'd4;
	localparam logic [2:0] REG_FADE_LENGTH    = 3'd5;

	localparam logic [1:0] FADE_NONE = 2'd0;
	localparam logic [1:0] FADE_LIN  = 2'd1;
	localparam logic [1:0] FADE_LOG  = 2'd2;

	localparam logic [15:0] GAIN_ONE  = 16'h8000;
	localparam int          LIN_STEPS = 15;

	typedef struct packed {
		logic [15:0] rel_volume;
		logic [1:0]  fade_mode;
		logic        fading_enabled;
		logic        play_forever;
		logic [31:0] track_length;
		logic [31:0] fade_length;
	} cfg_t;

	// One classified request as it waits between front and back.
	typedef struct packed {
		logic signed [15:0] sample_a;
		logic signed [15:0] sample_b;
		logic [15:0]        buffer_frames;
		logic               last;
		logic               fade;
		logic [33:0]        pos;
	} item_t;

	typedef struct packed {
		logic [1:0] count;
		logic       full;
	} q_stat_t;

	typedef struct packed {
		logic busy;
	} back_stat_t;

	// Per-entry ratio r in Q31 with r^depth just at or above one tenth.
	function automatic logic [63:0] exp_ratio(input int depth);
		logic [63:0] lo, hi, mid, acc;
		lo = 64'd0;
		hi = 64'd2147483648;
		while (lo < hi) begin
			mid = (lo + hi + 64'd1) >> 1;
			acc = 64'd2147483648;
			for (int i = 0; i < depth; i++) acc = (acc * mid) >> 31;
			if (acc >= 64'd214748365) lo = mid;
			else hi = mid - 64'd1;
		end
		return lo;
	endfunction

	function automatic logic [15:0] exp_entry(input logic [63:0] ratio, input int idx);
		logic [63:0] p;
		p = 64'd2147483648;
		for (int i = 0; i < idx; i++) p = (p * ratio) >> 31;
		return 16'((p + 64'd32768) >> 16);
	endfunction

endpackage

### sv/svfs_intf.sv
// ----------------------------------------------------------------------------
// svfs_intf
// Frame, result and configuration channels of the stereo volume block.
// ----------------------------------------------------------------------------
interface svfs_frame_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample_a;
	logic signed [15:0] sample_b;
	logic [15:0]        buffer_frames;
	logic               last_of_buffer;
	modport source(output valid, sample_a, sample_b, buffer_frames, last_of_buffer,
		input ready);
	modport sink(input valid, sample_a, sample_b, buffer_frames, last_of_buffer,
		output ready);
endinterface

interface svfs_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] out_first;
	logic signed [15:0] out_second;
	logic [31:0]        silence_frames;
	logic               end_of_buffer;
	modport source(output valid, out_first, out_second, silence_frames, end_of_buffer,
		input ready);
	modport sink(input valid, out_first, out_second, silence_frames, end_of_buffer,
		output ready);
endinterface

interface svfs_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  addr;
	logic [31:0] data;
	modport source(output valid, addr, data, input ready);
	modport sink(input valid, addr, data, output ready);
endinterface

### sv/svfs_front.sv
// ----------------------------------------------------------------------------
// svfs_front
// Tracks buffer time, decides the fade per buffer and computes fade position.
// ----------------------------------------------------------------------------
module svfs_front import svfs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg_i,
	input  q_stat_t q_stat,
	svfs_frame_if.sink frames,
	output logic  push,
	output item_t push_item
);

	logic [31:0] fbb_q;
	logic [15:0] fib_q;
	logic        fade_q;
	logic [32:0] t;
	logic [33:0] here;
	logic        fade_now;

	assign frames.ready = !q_stat.full;
	assign push = frames.valid && frames.ready;

	always_comb begin
		t = {1'b0, fbb_q} + 33'(frames.buffer_frames);
		here = {1'b0, t} + 34'(fib_q);
		if (fib_q == 16'd0) begin
			fade_now = cfg_i.fading_enabled && !cfg_i.play_forever &&
				(cfg_i.fade_mode inside {FADE_LIN, FADE_LOG}) &&
				(t >= {1'b0, cfg_i.track_length});
		end else begin
			fade_now = fade_q;
		end
		push_item.sample_a      = frames.sample_a;
		push_item.sample_b      = frames.sample_b;
		push_item.buffer_frames = frames.buffer_frames;
		push_item.last          = frames.last_of_buffer;
		push_item.fade          = fade_now;
		push_item.pos           = (here > 34'(cfg_i.track_length)) ?
			here - 34'(cfg_i.track_length) : 34'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fbb_q  <= '0;
			fib_q  <= '0;
			fade_q <= 1'b0;
		end else if (push) begin
			fade_q <= fade_now;
			if (frames.last_of_buffer) begin
				fib_q <= '0;
				fbb_q <= t[32] ? 32'hFFFF_FFFF : t[31:0];
			end else begin
				fib_q <= fib_q + 16'd1;
			end
		end
	end

endmodule

### sv/svfs_queue.sv
// ----------------------------------------------------------------------------
// svfs_queue
// Two-entry request queue between the front and the back.
// ----------------------------------------------------------------------------
module svfs_queue import svfs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  item_t   push_item,
	input  logic    pop,
	output item_t   head,
	output logic    head_valid,
	output q_stat_t stat
);

	item_t      mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign head       = mem_q[rd_q];
	assign head_valid = cnt_q != 2'd0;
	assign stat.count = cnt_q;
	assign stat.full  = cnt_q == 2'd2;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

### sv/svfs_back.sv
// ----------------------------------------------------------------------------
// svfs_back
// Fade gain sequencer, scaling multipliers, buffer sum and silence count.
// ----------------------------------------------------------------------------
module svfs_back import svfs_pkg::*; #(
	parameter int EXP_TABLE_DEPTH = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg_i,
	input  item_t      head,
	input  logic       head_valid,
	output logic       pop,
	output back_stat_t stat,
	svfs_result_if.source results
);

	localparam int          IDX_W = $clog2(EXP_TABLE_DEPTH);
	localparam logic [63:0] RATIO = exp_ratio(EXP_TABLE_DEPTH);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_INT  = 3'd1;
	localparam logic [2:0] ST_FRAC = 3'd2;
	localparam logic [2:0] ST_DEC  = 3'd3;
	localparam logic [2:0] ST_MUL1 = 3'd4;
	localparam logic [2:0] ST_MUL2 = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	localparam logic signed [34:0] SUM_LIM = 35'sd8589934591;

	logic [15:0] exp_rom [EXP_TABLE_DEPTH];

	for (genvar i = 0; i < EXP_TABLE_DEPTH; i++) begin : g_rom
		localparam logic [15:0] VAL = exp_entry(RATIO, i);
		assign exp_rom[i] = VAL;
	end

	logic [2:0]         state_q;
	item_t              item_q;
	logic [33:0]        r_q;
	logic [2:0]         k_q;
	logic [14:0]        qf_q;
	logic [3:0]         cnt_q;
	logic [15:0]        gain_q;
	logic signed [32:0] va_q, vb_q;
	logic signed [49:0] pa_q, pb_q;
	logic signed [34:0] sum_q;
	logic [31:0]        silent_q;
	logic               ovalid_q;
	logic signed [15:0] ofirst_q, osecond_q;
	logic [31:0]        osil_q;
	logic               oend_q;

	logic [31:0]        len;
	logic               lin;
	logic [3:0]         steps;
	logic [34:0]        r2;
	logic               ge;
	logic signed [15:0] oa, ob;
	logic signed [34:0] nsum;
	logic [32:0]        csum;
	logic [31:0]        nsil;
	logic               out_free;

	function automatic logic signed [15:0] round_sat(input logic signed [49:0] p);
		logic signed [49:0] v;
		v = (p + (50'sd1 <<< 26)) >>> 27;
		if (v > 50'sd32767) return 16'sh7FFF;
		if (v < -50'sd32768) return 16'sh8000;
		return v[15:0];
	endfunction

	assign len      = (cfg_i.fade_length == 32'd0) ? 32'd1 : cfg_i.fade_length;
	assign lin      = cfg_i.fade_mode == FADE_LIN;
	assign steps    = lin ? 4'(LIN_STEPS) : 4'(IDX_W);
	assign r2       = {r_q, 1'b0};
	assign ge       = r2 >= 35'(len);
	assign pop      = (state_q == ST_IDLE) && head_valid;
	assign stat.busy = state_q != ST_IDLE;
	assign out_free = !ovalid_q || results.ready;

	always_comb begin
		oa   = round_sat(pa_q);
		ob   = round_sat(pb_q);
		nsum = sum_q + 35'(oa) + 35'(ob);
		if (nsum > SUM_LIM) nsum = SUM_LIM;
		if (nsum < -SUM_LIM) nsum = -SUM_LIM;
		csum = {1'b0, silent_q} + 33'(item_q.buffer_frames);
		if (nsum != 35'sd0) nsil = '0;
		else nsil = csum[32] ? 32'hFFFF_FFFF : csum[31:0];
	end

	assign results.valid          = ovalid_q;
	assign results.out_first      = ofirst_q;
	assign results.out_second     = osecond_q;
	assign results.silence_frames = osil_q;
	assign results.end_of_buffer  = oend_q;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				item_q <= head;
				r_q    <= head.pos;
				k_q    <= '0;
				cnt_q  <= '0;
				qf_q   <= '0;
				gain_q <= GAIN_ONE;
			end
			ST_INT: begin
				if (r_q >= 34'(len) && k_q < 3'd5) begin
					r_q <= r_q - 34'(len);
					k_q <= k_q + 3'd1;
				end else if ((lin && k_q != 3'd0) || k_q == 3'd5) begin
					gain_q <= '0;
				end
			end
			ST_FRAC: begin
				if (cnt_q == steps) begin
					if (lin) gain_q <= GAIN_ONE - {1'b0, qf_q};
					else gain_q <= exp_rom[qf_q[IDX_W-1:0]];
				end else begin
					r_q   <= ge ? 34'(r2 - 35'(len)) : r2[33:0];
					qf_q  <= {qf_q[13:0], ge};
					cnt_q <= cnt_q + 4'd1;
				end
			end
			ST_DEC: begin
				if (k_q != 3'd0) begin
					// Floor division by ten, exact over the 16-bit range.
					gain_q <= 16'((32'(gain_q) * 32'd52429) >> 19);
					k_q    <= k_q - 3'd1;
				end
			end
			ST_MUL1: begin
				va_q <= item_q.sample_b * $signed({1'b0, cfg_i.rel_volume});
				vb_q <= item_q.sample_a * $signed({1'b0, cfg_i.rel_volume});
			end
			ST_MUL2: begin
				pa_q <= va_q * $signed({1'b0, gain_q});
				pb_q <= vb_q * $signed({1'b0, gain_q});
			end
			default: begin
			end
		endcase
		if (state_q == ST_OUT && out_free) begin
			ofirst_q  <= oa;
			osecond_q <= ob;
			oend_q    <= item_q.last;
			osil_q    <= item_q.last ? nsil : silent_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
			sum_q    <= '0;
			silent_q <= '0;
		end else begin
			if (results.ready) ovalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (head_valid) begin
						if (head.fade && (cfg_i.fade_mode inside {FADE_LIN, FADE_LOG}))
							state_q <= ST_INT;
						else
							state_q <= ST_MUL1;
					end
				end
				ST_INT: begin
					if (!(r_q >= 34'(len) && k_q < 3'd5)) begin
						if ((lin && k_q != 3'd0) || k_q == 3'd5) state_q <= ST_MUL1;
						else state_q <= ST_FRAC;
					end
				end
				ST_FRAC: if (cnt_q == steps) state_q <= ST_DEC;
				ST_DEC:  if (k_q == 3'd0) state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						ovalid_q <= 1'b1;
						state_q  <= ST_IDLE;
						if (item_q.last) begin
							sum_q    <= '0;
							silent_q <= nsil;
						end else begin
							sum_q <= nsum;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### sv/stereo_volume_fade_silence.sv
// ----------------------------------------------------------------------------
// stereo_volume_fade_silence
// Channel swap, volume and end-of-track fade with a per-buffer silence count.
// ----------------------------------------------------------------------------
//  channel   modport  carries
//  frames    sink     sample_a, sample_b, buffer_frames, last_of_buffer
//  results   source   out_first, out_second, silence_frames, end_of_buffer
//  cfg       sink     addr (register index), data; always ready
//
// A request without fade passes through the pop, two multiply stages and the
// output load in the back sequencer, which waits there while the output is held.
// A fade first divides the position by the fade length, then forms a serial
// quotient (15 bits linear, log2 of the table depth logarithmic) and divides by
// ten once per decade. The back takes a new request only after loading the last output.
// Reset is asynchronous and clears all time, sum and count state.
// The front keeps taking requests into a two-entry queue until it is full
// while the back or the output register is stalled.
`include "stereo_volume_fade_silence_assert.svh"

module stereo_volume_fade_silence import svfs_pkg::*; #(
	parameter int EXP_TABLE_DEPTH = 256
) (
	input logic clk,
	input logic arst_n,
	svfs_frame_if.sink     frames,
	svfs_result_if.source  results,
	svfs_cfg_if.sink       cfg
);

	cfg_t       cfg_q;
	logic       push;
	item_t      push_item;
	logic       pop;
	item_t      head;
	logic       head_valid;
	q_stat_t    q_stat;
	back_stat_t b_stat;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rel_volume     <= 16'd4096;
			cfg_q.fade_mode      <= FADE_NONE;
			cfg_q.fading_enabled <= 1'b0;
			cfg_q.play_forever   <= 1'b0;
			cfg_q.track_length   <= '0;
			cfg_q.fade_length    <= 32'd1;
		end else if (cfg.valid) begin
			case (cfg.addr)
				REG_REL_VOLUME:     cfg_q.rel_volume     <= cfg.data[15:0];
				REG_FADE_MODE:      cfg_q.fade_mode      <= cfg.data[1:0];
				REG_FADING_ENABLED: cfg_q.fading_enabled <= cfg.data[0];
				REG_PLAY_FOREVER:   cfg_q.play_forever   <= cfg.data[0];
				REG_TRACK_LENGTH:   cfg_q.track_length   <= cfg.data;
				REG_FADE_LENGTH:    cfg_q.fade_length    <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	svfs_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg_i(cfg_q), .q_stat(q_stat),
		.frames(frames), .push(push), .push_item(push_item)
	);

	svfs_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_item(push_item),
		.pop(pop), .head(head), .head_valid(head_valid), .stat(q_stat)
	);

	svfs_back #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg_i(cfg_q), .head(head),
		.head_valid(head_valid), .pop(pop), .stat(b_stat), .results(results)
	);

	`SVFS_ASSERT_SAME(a_queue_bound, 1'b1, q_stat.count != 2'd3)
	`SVFS_ASSERT_NEXT(a_request_kept, push, q_stat.count != 2'd0)
	`SVFS_ASSERT_SAME(a_pop_idle, pop, !b_stat.busy && head_valid)

endmodule

### tb/stereo_volume_fade_silence_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_volume_fade_silence_tb
// Drives random stereo buffers through the volume and fade block under several
// register settings and checks every result against a cycle-free predictor.
// ----------------------------------------------------------------------------
module stereo_volume_fade_silence_tb;
	import svfs_pkg::*;

	localparam int  TBL_DEPTH = 256;
	localparam int  CYCLE_LIMIT = 2000000;
	localparam int  SETTLE = 100;

	typedef struct {
		logic signed [15:0] a;
		logic signed [15:0] b;
		logic [15:0]        nframes;
		logic               last;
	} frame_t;

	typedef struct {
		logic signed [15:0] first;
		logic signed [15:0] second;
		logic [31:0]        silence;
		logic               eob;
	} scaled_t;

	logic clk;
	logic arst_n;

	svfs_frame_if  frames();
	svfs_result_if results();
	svfs_cfg_if    cfg();

	stereo_volume_fade_silence #(.EXP_TABLE_DEPTH(TBL_DEPTH)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.frames(frames),
		.results(results),
		.cfg(cfg)
	);

	// Predictor configuration and state.
	logic [15:0] vol;
	logic [1:0]  mode;
	logic        fade_en;
	logic        forever_on;
	logic [31:0] track_len;
	logic [31:0] fade_len;
	logic [31:0] elapsed;
	logic [15:0] frame_idx;
	logic        fading;
	longint      buf_sum;
	logic [31:0] silent_run;
	logic [15:0] decay_tbl [TBL_DEPTH];

	frame_t  pending_frames[$];
	scaled_t expected_out[$];
	int      mismatches;
	int      cycles;
	logic    quiet;
	logic    hold_tx;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	task automatic build_decay_table();
		logic [63:0] lo, hi, mid, acc, p;
		lo = 64'd0;
		hi = 64'd2147483648;
		while (lo < hi) begin
			mid = (lo + hi + 64'd1) >> 1;
			acc = 64'd2147483648;
			for (int i = 0; i < TBL_DEPTH; i++) acc = (acc * mid) >> 31;
			if (acc >= 64'd214748365) lo = mid;
			else hi = mid - 64'd1;
		end
		p = 64'd2147483648;
		for (int i = 0; i < TBL_DEPTH; i++) begin
			decay_tbl[i] = 16'((p + 64'd32768) >> 16);
			p = (p * lo) >> 31;
		end
	endtask

	function automatic longint fade_gain(longint pos);
		longint len, q, k, g;
		len = (fade_len == 0) ? 64'd1 : longint'(fade_len);
		if (mode == FADE_LIN) begin
			q = (pos * 32768) / len;
			return (q >= 32768) ? 0 : 32768 - q;
		end
		if (mode == FADE_LOG) begin
			q = (pos * TBL_DEPTH) / len;
			k = q / TBL_DEPTH;
			if (k > 4) return 0;
			g = decay_tbl[q % TBL_DEPTH];
			for (int i = 0; i < k; i++) g = g / 10;
			return g;
		end
		return 32768;
	endfunction

	function automatic logic signed [15:0] apply_gain(logic signed [15:0] s, longint g);
		longint p, v, r;
		p = longint'(s) * longint'(vol) * g;
		v = p + (longint'(1) << 26);
		if (v >= 0) r = v >>> 27;
		else r = -((-v + (longint'(1) << 27) - 1) >>> 27);
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return 16'(r);
	endfunction

	// Advances the buffer state by one frame and returns the result it yields.
	function automatic scaled_t scale_frame(frame_t f);
		scaled_t o;
		longint t, here, pos, g;
		t = longint'(elapsed) + longint'(f.nframes);
		g = 32768;
		if (frame_idx == 0)
			fading = fade_en && !forever_on && (mode == FADE_LIN || mode == FADE_LOG)
				&& t >= longint'(track_len);
		if (fading) begin
			here = t + frame_idx;
			pos = (here > longint'(track_len)) ? here - longint'(track_len) : 0;
			g = fade_gain(pos);
		end
		o.first = apply_gain(f.b, g);
		o.second = apply_gain(f.a, g);
		buf_sum += longint'(o.first) + longint'(o.second);
		if (buf_sum > 64'sd8589934591) buf_sum = 64'sd8589934591;
		if (buf_sum < -64'sd8589934591) buf_sum = -64'sd8589934591;
		if (f.last) begin
			if (buf_sum == 0) begin
				if (longint'(silent_run) + f.nframes > 64'd4294967295)
					silent_run = 32'hFFFF_FFFF;
				else
					silent_run = silent_run + f.nframes;
			end else begin
				silent_run = 0;
			end
			elapsed = (t > 64'd4294967295) ? 32'hFFFF_FFFF : 32'(t);
			frame_idx = 0;
			buf_sum = 0;
		end else begin
			frame_idx = frame_idx + 16'd1;
		end
		o.silence = silent_run;
		o.eob = f.last;
		return o;
	endfunction

	// Frame driver. A request that is waiting for ready is held unchanged.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames.valid <= 1'b0;
		end else begin
			if (frames.valid && frames.ready) begin
				expected_out.push_back(scale_frame(pending_frames.pop_front()));
			end
			if (!(frames.valid && !frames.ready)) begin
				if (pending_frames.size() == 0 || hold_tx
					|| (!quiet && $urandom_range(0, 99) < 10)) begin
					frames.valid <= 1'b0;
				end else begin
					frames.valid <= 1'b1;
					frames.sample_a <= pending_frames[0].a;
					frames.sample_b <= pending_frames[0].b;
					frames.buffer_frames <= pending_frames[0].nframes;
					frames.last_of_buffer <= pending_frames[0].last;
				end
			end
		end
	end

	// Result monitor.
	always @(posedge clk or negedge arst_n) begin
		scaled_t e;
		if (!arst_n) begin
			results.ready <= 1'b0;
		end else begin
			if (results.valid && results.ready) begin
				if (expected_out.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: %0d %0d %0d %0d", results.out_first,
							results.out_second, results.silence_frames, results.end_of_buffer);
				end else begin
					e = expected_out.pop_front();
					if (results.out_first !== e.first || results.out_second !== e.second
						|| results.silence_frames !== e.silence
						|| results.end_of_buffer !== e.eob) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
								e.first, e.second, e.silence, e.eob, results.out_first,
								results.out_second, results.silence_frames,
								results.end_of_buffer);
					end
				end
			end
			results.ready <= quiet || $urandom_range(0, 99) >= 10;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[stereo_volume_fade_silence] ERROR");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] value);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.addr <= idx;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		case (idx)
			REG_REL_VOLUME:     vol = value[15:0];
			REG_FADE_MODE:      mode = value[1:0];
			REG_FADING_ENABLED: fade_en = value[0];
			REG_PLAY_FOREVER:   forever_on = value[0];
			REG_TRACK_LENGTH:   track_len = value;
			REG_FADE_LENGTH:    fade_len = value;
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (pending_frames.size() != 0 || expected_out.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic push_frame(logic [15:0] a, logic [15:0] b, logic [15:0] n, logic last);
		frame_t f;
		f.a = a;
		f.b = b;
		f.nframes = n;
		f.last = last;
		pending_frames.push_back(f);
	endtask

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'hFFFF;
			3: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	// Adds one buffer; sometimes it is silent, has a stray frame count or no last mark.
	task automatic add_buffer(int max_len);
		int len;
		logic [15:0] n;
		logic hush, tail;
		len = $urandom_range(1, max_len);
		n = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'(len);
		hush = $urandom_range(0, 99) < 30;
		tail = $urandom_range(0, 19) != 0;
		for (int i = 0; i < len; i++)
			push_frame(hush ? 16'd0 : pick_sample(), hush ? 16'd0 : pick_sample(), n,
				tail && i == len - 1);
	endtask

	initial begin
		logic [31:0] tl, fl;
		int target;
		arst_n = 1'b0;
		cycles = 0;
		mismatches = 0;
		quiet = 1'b0;
		hold_tx = 1'b0;
		frames.valid = 1'b0;
		frames.sample_a = '0;
		frames.sample_b = '0;
		frames.buffer_frames = '0;
		frames.last_of_buffer = 1'b0;
		results.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.addr = '0;
		cfg.data = '0;
		vol = 16'd4096;
		mode = FADE_NONE;
		fade_en = 1'b0;
		forever_on = 1'b0;
		track_len = 32'd0;
		fade_len = 32'd1;
		elapsed = 32'd0;
		frame_idx = 16'd0;
		fading = 1'b0;
		buf_sum = 0;
		silent_run = 32'd0;
		build_decay_table();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: full-scale and rounding samples at unity, then silent buffers.
		push_frame(16'h7FFF, 16'h8000, 16'd4, 1'b0);
		push_frame(16'h8000, 16'h7FFF, 16'd4, 1'b0);
		push_frame(16'hFFFF, 16'h0001, 16'd4, 1'b0);
		push_frame(16'h0000, 16'h0000, 16'd4, 1'b1);
		push_frame(16'h0000, 16'h0000, 16'd2, 1'b0);
		push_frame(16'h0000, 16'h0000, 16'd2, 1'b1);
		push_frame(16'h0000, 16'h0000, 16'hFFFF, 1'b1);
		push_frame(16'h0000, 16'h0000, 16'd0, 1'b1);
		wait_drained();
		write_reg(REG_REL_VOLUME, 32'd65535);
		push_frame(16'h7FFF, 16'h8000, 16'd3, 1'b0);
		push_frame(16'h0001, 16'hFFFF, 16'd3, 1'b0);
		push_frame(16'h0000, 16'h0000, 16'd3, 1'b1);
		wait_drained();

		for (int ph = 0; ph < 12; ph++) begin
			tl = elapsed + $urandom_range(0, 40);
			fl = $urandom_range(1, 300);
			case (ph)
				0: write_reg(REG_REL_VOLUME, 32'd0);
				1: write_reg(REG_REL_VOLUME, 32'd65535);
				default: write_reg(REG_REL_VOLUME, $urandom_range(0, 12000));
			endcase
			write_reg(REG_FADE_MODE, (ph == 5) ? 32'd3 : (ph == 6) ? 32'd0 : 32'(ph % 2 + 1));
			write_reg(REG_FADING_ENABLED, (ph == 7) ? 32'd0 : 32'd1);
			write_reg(REG_PLAY_FOREVER, (ph == 8) ? 32'd1 : 32'd0);
			write_reg(REG_TRACK_LENGTH, (ph == 9) ? 32'hFFFF_FFFF : (ph == 2) ? 32'd0 : tl);
			write_reg(REG_FADE_LENGTH, (ph == 3) ? 32'd0 : (ph == 4) ? 32'hFFFF_FFFF :
				(ph == 10) ? 32'd1 : fl);
			quiet = (ph == 6);
			target = pending_frames.size() + 70;
			while (pending_frames.size() < target)
				add_buffer((ph % 3 == 0) ? 40 : 8);
			if (ph == 1) begin
				while (pending_frames.size() > 30) @(posedge clk);
				hold_tx = 1'b1;
				while (expected_out.size() != 0 || frames.valid) @(posedge clk);
				hold_tx = 1'b0;
			end
			wait_drained();
			quiet = 1'b0;
		end

		if (mismatches == 0)
			$display("[stereo_volume_fade_silence] OK");
		else
			$display("[stereo_volume_fade_silence] ERROR");
		$finish;
	end
endmodule

### filelist.f
+incdir+sv
sv/svfs_pkg.sv
sv/svfs_intf.sv
sv/svfs_front.sv
sv/svfs_queue.sv
sv/svfs_back.sv
sv/stereo_volume_fade_silence.sv
tb/stereo_volume_fade_silence_tb.sv
